/* rtl/tpiu_pkg.sv */
`timescale 1ns / 1ps
// tpiu_pkg: shared types, constants and helpers of the tiled palette image unpacker
// no dependencies

package tpiu_pkg;

  localparam int TILE_W      = 6;
  localparam int TILE_SIZE   = 1 << TILE_W;
  localparam int TILES_W     = 10;
  localparam int MAX_TILES   = 1 << TILES_W;
  localparam int DIM_W       = 16;
  localparam int CNT_W       = TILES_W + 1;
  localparam int OFFSET_W    = 32;
  localparam int PAL_DEPTH   = 256;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_PIXEL   = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TILE_COLUMNS = 2'd2,
    REG_TILE_ROWS    = 2'd3
  } reg_e;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [CNT_W-1:0] tile_columns;
    logic [CNT_W-1:0] tile_rows;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [7:0]       index;
    rgba_t            colour;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic             done;
  } cmd_t;

  // size of an edge tile: remainder, or a full tile when exact
  function automatic logic [TILE_W:0] edge_extent(logic [DIM_W-1:0] size);
    logic [TILE_W:0] ext;
    ext = (size[TILE_W-1:0] == '0) ? (TILE_W+1)'(TILE_SIZE) : {1'b0, size[TILE_W-1:0]};
    return ext;
  endfunction

  // tile count clamped to 1 .. MAX_TILES
  function automatic logic [CNT_W-1:0] clamp_tiles(logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] c;
    if (n == '0) begin
      c = CNT_W'(1);
    end else if (n > CNT_W'(MAX_TILES)) begin
      c = CNT_W'(MAX_TILES);
    end else begin
      c = n;
    end
    return c;
  endfunction

endpackage

/* rtl/tiled_palette_image_unpacker.sv */
`timescale 1ns / 1ps
// tiled_palette_image_unpacker: top level with configuration registers,
// front, command queue and back; uses tpiu_pkg, tpiu_front, tpiu_queue, tpiu_back

// Takes one word per clock while the queue is not full and results are popped
// as they appear, and returns one result word per pixel word; palette writes
// return nothing. A pushed word is stored in the command queue; its result
// shows on the output ports once the back has loaded its palette read /
// row-times-width multiply register from the queue head, which it does only
// while its output word is free or being popped. The palette memory has no
// reset: pixels that index an entry never written return undefined colour. Pixel
// offset is (tile row * 64 + row) * width + column, modulo 2^32; the user must
// write configuration only while no word is in flight; the block does not check.

module tiled_palette_image_unpacker import tpiu_pkg::*; #(
  parameter int PaletteDepth = PAL_DEPTH,
  parameter int QueueDepth   = QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i,
  input  logic                 push,
  output logic                 full,
  input  logic                 op_i,
  input  logic [7:0]           entry_index_i,
  input  logic [7:0]           entry_red_i,
  input  logic [7:0]           entry_green_i,
  input  logic [7:0]           entry_blue_i,
  input  logic [7:0]           entry_alpha_i,
  input  logic [7:0]           pixel_index_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [OFFSET_W-1:0]  pixel_offset_o,
  output logic [7:0]           out_alpha_o,
  output logic [7:0]           out_blue_o,
  output logic [7:0]           out_green_o,
  output logic [7:0]           out_red_o,
  output logic                 image_done_o
);

  cfg_t cfg_q, cfg_d;
  logic q_wr_en, q_rd_en, q_empty, q_full;
  cmd_t q_wdata, q_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  cfg_d.image_width  = cfg_wdata_i;
        REG_IMAGE_HEIGHT: cfg_d.image_height = cfg_wdata_i;
        REG_TILE_COLUMNS: cfg_d.tile_columns = cfg_wdata_i[CNT_W-1:0];
        REG_TILE_ROWS:    cfg_d.tile_rows    = cfg_wdata_i[CNT_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= DIM_W'(TILE_SIZE);
      cfg_q.image_height <= DIM_W'(TILE_SIZE);
      cfg_q.tile_columns <= CNT_W'(1);
      cfg_q.tile_rows    <= CNT_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign full = q_full;

  tpiu_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg_q),
    .push,
    .q_full_i      (q_full),
    .op_i,
    .entry_index_i,
    .entry_red_i,
    .entry_green_i,
    .entry_blue_i,
    .entry_alpha_i,
    .pixel_index_i,
    .q_wr_en_o     (q_wr_en),
    .q_wdata_o     (q_wdata)
  );

  tpiu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .wr_en_i (q_wr_en),
    .wdata_i (q_wdata),
    .rd_en_i (q_rd_en),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tpiu_back #(
    .PaletteDepth (PaletteDepth)
  ) u_back (
    .clk_i,
    .rst_ni,
    .image_width_i  (cfg_q.image_width),
    .q_empty_i      (q_empty),
    .q_rdata_i      (q_rdata),
    .q_rd_en_o      (q_rd_en),
    .pop,
    .empty,
    .pixel_offset_o,
    .out_alpha_o,
    .out_blue_o,
    .out_green_o,
    .out_red_o,
    .image_done_o
  );

endmodule

/* rtl/tpiu_front.sv */
`timescale 1ns / 1ps
// tpiu_front: accepts input words, walks the tile and pixel counters and
// forms one command per word for the queue; uses tpiu_pkg

module tpiu_front import tpiu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       push,
  input  logic       q_full_i,
  input  logic       op_i,
  input  logic [7:0] entry_index_i,
  input  logic [7:0] entry_red_i,
  input  logic [7:0] entry_green_i,
  input  logic [7:0] entry_blue_i,
  input  logic [7:0] entry_alpha_i,
  input  logic [7:0] pixel_index_i,
  output logic       q_wr_en_o,
  output cmd_t       q_wdata_o
);

  logic [TILES_W-1:0] tile_col_q, tile_col_d;
  logic [TILES_W-1:0] tile_row_q, tile_row_d;
  logic [TILE_W-1:0]  col_q, col_d;
  logic [TILE_W-1:0]  row_q, row_d;

  logic [CNT_W-1:0] cols, rows, tcol_inc, trow_inc;
  logic [TILE_W:0]  bw, bh, col_inc, row_inc;
  logic             last_col, last_row, col_wrap, row_wrap;
  logic             accept, is_pixel;
  op_e              op;

  assign op       = op_e'(op_i);
  assign accept   = push && !q_full_i;
  assign is_pixel = (op == OP_PIXEL);

  always_comb begin
    cols     = clamp_tiles(cfg_i.tile_columns);
    rows     = clamp_tiles(cfg_i.tile_rows);
    last_col = {1'b0, tile_col_q} >= (cols - CNT_W'(1));
    last_row = {1'b0, tile_row_q} >= (rows - CNT_W'(1));
    bw       = last_col ? edge_extent(cfg_i.image_width)  : (TILE_W+1)'(TILE_SIZE);
    bh       = last_row ? edge_extent(cfg_i.image_height) : (TILE_W+1)'(TILE_SIZE);
    col_inc  = {1'b0, col_q} + (TILE_W+1)'(1);
    row_inc  = {1'b0, row_q} + (TILE_W+1)'(1);
    col_wrap = col_inc >= bw;
    row_wrap = row_inc >= bh;
    tcol_inc = {1'b0, tile_col_q} + CNT_W'(1);
    trow_inc = {1'b0, tile_row_q} + CNT_W'(1);
  end

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    tile_col_d = tile_col_q;
    tile_row_d = tile_row_q;
    if (accept && is_pixel) begin
      if (!col_wrap) begin
        col_d = col_inc[TILE_W-1:0];
      end else begin
        col_d = '0;
        if (!row_wrap) begin
          row_d = row_inc[TILE_W-1:0];
        end else begin
          row_d = '0;
          if (tcol_inc < cols) begin
            tile_col_d = tcol_inc[TILES_W-1:0];
          end else begin
            tile_col_d = '0;
            tile_row_d = (trow_inc < rows) ? trow_inc[TILES_W-1:0] : '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_col_q <= '0;
      tile_row_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      tile_col_q <= tile_col_d;
      tile_row_q <= tile_row_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

  always_comb begin
    q_wdata_o.op           = op;
    q_wdata_o.index        = is_pixel ? pixel_index_i : entry_index_i;
    q_wdata_o.colour.alpha = entry_alpha_i;
    q_wdata_o.colour.blue  = entry_blue_i;
    q_wdata_o.colour.green = entry_green_i;
    q_wdata_o.colour.red   = entry_red_i;
    q_wdata_o.x            = {tile_col_q, col_q};
    q_wdata_o.y            = {tile_row_q, row_q};
    q_wdata_o.done         = last_col && last_row && col_wrap && row_wrap;
  end

  assign q_wr_en_o = accept;

endmodule

/* rtl/tpiu_queue.sv */
`timescale 1ns / 1ps
// tpiu_queue: short command queue between front and back
// uses tpiu_pkg for the command type

module tpiu_queue import tpiu_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  cmd_t wdata_i,
  input  logic rd_en_i,
  output cmd_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + CntW'(1);
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_no_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> count_q != '0)
    else $error("queue read while empty");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> count_q != CntW'(Depth))
    else $error("queue write while full");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i && !rd_en_i) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not follow write");
`endif

endmodule

/* rtl/tpiu_back.sv */
`timescale 1ns / 1ps
// tpiu_back: palette memory, offset multiplier and output word register
// uses tpiu_pkg

module tpiu_back import tpiu_pkg::*; #(
  parameter int PaletteDepth = PAL_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [DIM_W-1:0]    image_width_i,
  input  logic                q_empty_i,
  input  cmd_t                q_rdata_i,
  output logic                q_rd_en_o,
  input  logic                pop,
  output logic                empty,
  output logic [OFFSET_W-1:0] pixel_offset_o,
  output logic [7:0]          out_alpha_o,
  output logic [7:0]          out_blue_o,
  output logic [7:0]          out_green_o,
  output logic [7:0]          out_red_o,
  output logic                image_done_o
);

  localparam int AddrW = (PaletteDepth > 1) ? $clog2(PaletteDepth) : 1;

  rgba_t               pal_mem [PaletteDepth];
  rgba_t               rd_q;
  logic [OFFSET_W-1:0] prod_q;
  logic [DIM_W-1:0]    x_q;
  logic                done_q, hit_q;
  logic                valid_q, valid_d;

  logic                stage_free, pix_go, wr_go, in_range, out_taken;
  logic [AddrW-1:0]    addr;
  rgba_t               colour;

  assign out_taken  = pop && valid_q;
  assign stage_free = !valid_q || pop;
  assign q_rd_en_o  = !q_empty_i && ((q_rdata_i.op == OP_PALETTE) || stage_free);
  assign pix_go     = q_rd_en_o && (q_rdata_i.op == OP_PIXEL);
  assign in_range   = {1'b0, q_rdata_i.index} < 9'(PaletteDepth);
  assign wr_go      = q_rd_en_o && (q_rdata_i.op == OP_PALETTE) && in_range;
  assign addr       = q_rdata_i.index[AddrW-1:0];

  always_comb begin
    valid_d = valid_q;
    if (pix_go) begin
      valid_d = 1'b1;
    end else if (out_taken) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // palette memory, one port used per cycle
  always_ff @(posedge clk_i) begin
    if (wr_go) begin
      pal_mem[addr] <= q_rdata_i.colour;
    end
    if (pix_go) begin
      rd_q <= pal_mem[addr];
    end
  end

  // row times width
  always_ff @(posedge clk_i) begin
    if (pix_go) begin
      prod_q <= OFFSET_W'(q_rdata_i.y) * OFFSET_W'(image_width_i);
      x_q    <= q_rdata_i.x;
      done_q <= q_rdata_i.done;
      hit_q  <= in_range;
    end
  end

  assign colour         = hit_q ? rd_q : '0;
  assign empty          = !valid_q;
  assign pixel_offset_o = prod_q + OFFSET_W'(x_q);
  assign out_alpha_o    = colour.alpha;
  assign out_blue_o     = colour.blue;
  assign out_green_o    = colour.green;
  assign out_red_o      = colour.red;
  assign image_done_o   = done_q;

`ifndef SYNTHESIS
  a_pixel_loads_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_go |=> valid_q)
    else $error("pixel word not loaded into output stage");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !pop) |-> !pix_go)
    else $error("output word overwritten while waiting");

  a_write_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_go && !valid_q) |=> !valid_q)
    else $error("palette write produced a result word");
`endif

endmodule
